// ===== design/vsns_pkg.sv =====
// Shared types and constants of the six-neighbor volume smoothing block.
package vsns_pkg;

  // Configuration port.
  localparam int CFG_W      = 7;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_DEPTH  = 2'd2;

  // Input word kinds.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // The divisor is twice the neighbor count, at most twelve.
  localparam int DEN_W = 4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/vsns_div.sv =====
// Sequential floor divider of a signed numerator by a small positive divisor.
module vsns_div #(
  parameter int NW = 21
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [NW-1:0]        num,
  input  logic [vsns_pkg::DEN_W-1:0]  den,
  output logic signed [NW-1:0]        quot,
  output vsns_pkg::div_stat_t         stat
);
  import vsns_pkg::*;

  localparam int CW = $clog2(NW);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [NW-1:0]     quo_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [CW-1:0]     cnt_r;

  logic [NW-1:0]     mag;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              fits;

  // A negative numerator is divided as a ceiling on its magnitude, which
  // turns the truncating quotient into a floor once the sign is put back.
  assign mag     = num[NW-1] ? (~num + NW'(den)) : num;
  assign rem_sh  = {rem_r, quo_r[NW-1]};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  assign quot = neg_r ? (~quo_r + NW'(1)) : quo_r;
  assign stat = '{busy: busy_r, done: done_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NW-1];
      quo_r <= mag;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= CW'(NW - 1);
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], fits};
      rem_r <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ===== design/volume_six_neighbor_smoothing.sv =====
// Top level of the six-neighbor smoothing filter over a streamed 3D volume.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------
//   in      | input     | in_valid / in_ready   | in_cmd, in_sample_value
//   out     | output    | out_valid / out_ready | out_smoothed_value, out_last_voxel
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A word that gives a result passes through paired reads from the two-plane
// store, then the bit-serial divider that forms the rounded mean (one quotient
// bit per cycle over SAMPLE_BITS + 5 bits). The store needs no clearing after
// reset. A stalled output holds the sequencer once the next result is ready.
module volume_six_neighbor_smoothing #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int MAX_DEPTH   = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_smoothed_value,
  output logic                              out_last_voxel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vsns_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [vsns_pkg::CFG_W-1:0]        cfg_data
);
  import vsns_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int ZW    = $clog2(MAX_DEPTH);
  localparam int WDW   = $clog2(MAX_WIDTH + 1);
  localparam int HDW   = $clog2(MAX_HEIGHT + 1);
  localparam int DDW   = $clog2(MAX_DEPTH + 1);
  localparam int AW    = 1 + YW + XW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = SAMPLE_BITS + 3;
  localparam int NW    = SAMPLE_BITS + 5;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD0   = 3'd1;
  localparam logic [2:0] ST_RD1   = 3'd2;
  localparam logic [2:0] ST_RD2   = 3'd3;
  localparam logic [2:0] ST_RD3   = 3'd4;
  localparam logic [2:0] ST_START = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_PUT   = 3'd7;

  function automatic int sat_dim(int v, int top);
    if (v < 2) return 2;
    if (v > top) return top;
    return v;
  endfunction

  // Control state.
  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] grid_w_r, grid_h_r, grid_d_r;
  logic [XW-1:0]    in_x_r;
  logic [YW-1:0]    in_y_r;
  logic [ZW-1:0]    in_z_r;
  logic [XW-1:0]    fl_x_r;
  logic [YW-1:0]    fl_y_r;
  logic             emitted_r;
  logic             out_valid_r;

  // Per-item working registers.
  logic [XW-1:0]    cx_r;
  logic [YW-1:0]    cy_r;
  logic             cur_r;
  logic             has_up_r, has_dn_r, has_l_r, has_r_r, has_ym_r, has_yp_r;
  logic [2:0]       cnt_r;
  logic signed [SAMPLE_BITS-1:0] up_r;
  logic signed [SAMPLE_BITS-1:0] own_r;
  logic signed [SW-1:0]          sum_r;
  logic             pend_wr_r;
  logic [AW-1:0]    wr_addr_r;
  logic             last_r;
  logic signed [SAMPLE_BITS-1:0] out_val_r;
  logic             out_last_r;

  // Two-plane store.
  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]    rd_a_addr, rd_b_addr, wr_addr;
  logic signed [SAMPLE_BITS-1:0] wr_data;
  logic             we;

  logic [WDW-1:0]   w_sat;
  logic [HDW-1:0]   h_sat;
  logic [DDW-1:0]   d_sat;
  logic             vol_done, in_acc, cfg_acc, cfg_hit;
  logic             smp_go, smp_out, fl_go, go;
  logic             x_end, y_end, z_end, fx_end, fy_end;
  logic [XW-1:0]    cx;
  logic [YW-1:0]    cy;
  logic             cur, has_up, has_dn, has_l, has_r, has_ym, has_yp;

  logic                   div_start;
  logic signed [NW-1:0]   div_num;
  logic [DEN_W-1:0]       div_den;
  logic signed [NW-1:0]   div_q;
  div_stat_t              div_stat;
  logic signed [SAMPLE_BITS-1:0] result;
  logic             slot_free, take, load;

  assign w_sat = WDW'(sat_dim(int'(grid_w_r), MAX_WIDTH));
  assign h_sat = HDW'(sat_dim(int'(grid_h_r), MAX_HEIGHT));
  assign d_sat = DDW'(sat_dim(int'(grid_d_r), MAX_DEPTH));

  assign in_ready  = state_r == ST_IDLE;
  assign cfg_ready = state_r == ST_IDLE;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_acc && (cfg_index == REG_GRID_WIDTH ||
                                 cfg_index == REG_GRID_HEIGHT ||
                                 cfg_index == REG_GRID_DEPTH);

  // The whole volume has arrived once the input position has wrapped back to
  // the origin after results were given.
  assign vol_done = in_x_r == '0 && in_y_r == '0 && in_z_r == '0 && emitted_r;

  assign smp_go  = in_acc && in_cmd == CMD_SAMPLE && !vol_done;
  assign smp_out = smp_go && in_z_r != '0;
  assign fl_go   = in_acc && in_cmd == CMD_FLUSH && vol_done;
  assign go      = smp_out || fl_go;

  assign x_end  = in_x_r == XW'(w_sat - WDW'(1));
  assign y_end  = in_y_r == YW'(h_sat - HDW'(1));
  assign z_end  = in_z_r == ZW'(d_sat - DDW'(1));
  assign fx_end = fl_x_r == XW'(w_sat - WDW'(1));
  assign fy_end = fl_y_r == YW'(h_sat - HDW'(1));

  // A sample emits the voxel just below it; a flush emits the next voxel of
  // the final plane, whose lower neighbor plane sits in the other slot.
  assign cx     = fl_go ? fl_x_r : in_x_r;
  assign cy     = fl_go ? fl_y_r : in_y_r;
  assign cur    = fl_go ? ~d_sat[0] : ~in_z_r[0];
  assign has_up = !fl_go;
  assign has_dn = fl_go || in_z_r > ZW'(1);
  assign has_l  = cx != '0;
  assign has_r  = cx != XW'(w_sat - WDW'(1));
  assign has_ym = cy != '0;
  assign has_yp = cy != YW'(h_sat - HDW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r  <= CFG_W'(64);
      grid_h_r  <= CFG_W'(64);
      grid_d_r  <= CFG_W'(64);
      in_x_r    <= '0;
      in_y_r    <= '0;
      in_z_r    <= '0;
      fl_x_r    <= '0;
      fl_y_r    <= '0;
      emitted_r <= 1'b0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_w_r <= cfg_data;
        REG_GRID_HEIGHT: grid_h_r <= cfg_data;
        default:         grid_d_r <= cfg_data;
      endcase
      in_x_r    <= '0;
      in_y_r    <= '0;
      in_z_r    <= '0;
      fl_x_r    <= '0;
      fl_y_r    <= '0;
      emitted_r <= 1'b0;
    end else if (smp_go) begin
      if (smp_out) emitted_r <= 1'b1;
      if (!x_end) begin
        in_x_r <= in_x_r + XW'(1);
      end else begin
        in_x_r <= '0;
        if (!y_end) begin
          in_y_r <= in_y_r + YW'(1);
        end else begin
          in_y_r <= '0;
          in_z_r <= z_end ? '0 : in_z_r + ZW'(1);
        end
      end
    end else if (fl_go) begin
      if (!fx_end) begin
        fl_x_r <= fl_x_r + XW'(1);
      end else begin
        fl_x_r <= '0;
        if (!fy_end) begin
          fl_y_r <= fl_y_r + YW'(1);
        end else begin
          fl_y_r    <= '0;
          emitted_r <= 1'b0;
        end
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (go) state_nxt = ST_RD0;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_RD3;
      ST_RD3:   state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_stat.done) state_nxt = slot_free ? ST_IDLE : ST_PUT;
      ST_PUT:   if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cx_r      <= cx;
      cy_r      <= cy;
      cur_r     <= cur;
      has_up_r  <= has_up;
      has_dn_r  <= has_dn;
      has_l_r   <= has_l;
      has_r_r   <= has_r;
      has_ym_r  <= has_ym;
      has_yp_r  <= has_yp;
      cnt_r     <= 3'($countones({has_up, has_dn, has_l, has_r, has_ym, has_yp}));
      up_r      <= in_sample_value;
      pend_wr_r <= smp_out;
      wr_addr_r <= {in_z_r[0], in_y_r, in_x_r};
      last_r    <= fl_go && fx_end && fy_end;
    end
  end

  // Read pairs: own and lower plane, then the x pair, then the y pair.
  always_comb begin
    case (state_r)
      ST_RD0: begin
        rd_a_addr = {cur_r, cy_r, cx_r};
        rd_b_addr = {~cur_r, cy_r, cx_r};
      end
      ST_RD1: begin
        rd_a_addr = {cur_r, cy_r, cx_r - XW'(1)};
        rd_b_addr = {cur_r, cy_r, cx_r + XW'(1)};
      end
      default: begin
        rd_a_addr = {cur_r, cy_r - YW'(1), cx_r};
        rd_b_addr = {cur_r, cy_r + YW'(1), cx_r};
      end
    endcase
  end

  // The incoming sample overwrites the lower-plane entry read in the first
  // pair, so its write waits until all reads are issued.
  assign we      = (smp_go && in_z_r == '0) || (state_r == ST_RD3 && pend_wr_r);
  assign wr_addr = (state_r == ST_RD3) ? wr_addr_r : {in_z_r[0], in_y_r, in_x_r};
  assign wr_data = (state_r == ST_RD3) ? up_r : in_sample_value;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_RD1: begin
        own_r <= rd_a_q;
        sum_r <= (has_dn_r ? SW'(rd_b_q) : SW'(0)) + (has_up_r ? SW'(up_r) : SW'(0));
      end
      ST_RD2: sum_r <= sum_r + (has_l_r ? SW'(rd_a_q) : SW'(0))
                             + (has_r_r ? SW'(rd_b_q) : SW'(0));
      ST_RD3: sum_r <= sum_r + (has_ym_r ? SW'(rd_a_q) : SW'(0))
                             + (has_yp_r ? SW'(rd_b_q) : SW'(0));
      default: ;
    endcase
  end

  // Rounded mean is floor((2 * sum + count) / (2 * count)).
  assign div_start = state_r == ST_START;
  assign div_num   = NW'($signed({sum_r, 1'b0})) + NW'(cnt_r);
  assign div_den   = {cnt_r, 1'b0};

  vsns_div #(
    .NW (NW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_q),
    .stat  (div_stat)
  );

  assign result = (NW'(own_r) < div_q) ? own_r : div_q[SAMPLE_BITS-1:0];

  // Output word register.
  assign take      = out_valid_r && out_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign load      = ((state_r == ST_DIV && div_stat.done) || state_r == ST_PUT) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_val_r  <= result;
      out_last_r <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_value = out_val_r;
  assign out_last_voxel     = out_last_r;

endmodule
